### rtl/mts_pkg.sv
// shared constants, types and helpers of the memory type selector
package mts_pkg;

  localparam int MAX_TYPES = 32;
  localparam int MAX_HEAPS = 16;
  localparam int TYPE_AW   = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int HEAP_AW   = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
  localparam int CNT_W     = 6;
  localparam int IDX_W     = 5;
  localparam int HEAPNUM_W = 4;
  localparam int PROPS_W   = 32;
  localparam int BYTES_W   = 64;
  localparam int SCORE_W   = 6;

  localparam logic [1:0] OP_LOAD_TYPE = 2'd0;
  localparam logic [1:0] OP_LOAD_HEAP = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  localparam logic [1:0] CFG_TYPE_COUNT = 2'd0;
  localparam logic [1:0] CFG_FORBIDDEN  = 2'd1;
  localparam logic [1:0] CFG_EXCL_HEAP  = 2'd2;

  typedef struct packed {
    logic [PROPS_W-1:0] allowed;
    logic [PROPS_W-1:0] req;
    logic [PROPS_W-1:0] pref;
    logic [PROPS_W-1:0] avoid;
    logic [BYTES_W-1:0] min_bytes;
  } query_t;

  typedef struct packed {
    logic [PROPS_W-1:0] forbidden;
    logic [PROPS_W-1:0] excl_heap;
  } policy_t;

  function automatic logic [SCORE_W-1:0] bit_count(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] p;
    a = v - ((v >> 1) & 32'h55555555);
    b = (a & 32'h33333333) + ((a >> 2) & 32'h33333333);
    c = (b + (b >> 4)) & 32'h0f0f0f0f;
    p = c * 32'h01010101;
    return p[29:24];
  endfunction

endpackage

### rtl/mts_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### rtl/mts_eval.sv
// candidate qualification stage and best-candidate tracking
module mts_eval import mts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic               in_v,
  input  logic [IDX_W-1:0]   idx,
  input  logic [PROPS_W-1:0] props,
  input  logic               heap_ok,
  input  logic [BYTES_W-1:0] heap_size,
  input  logic [PROPS_W-1:0] heap_flags,
  input  query_t             qry,
  input  policy_t            pol,
  output logic               busy,
  output logic               have_r,
  output logic [IDX_W-1:0]   best_idx_r
);

  logic               ok;
  logic               cand_v_r;
  logic [IDX_W-1:0]   cand_idx_r;
  logic               cand_av_r;
  logic [SCORE_W-1:0] cand_score_r;
  logic [BYTES_W-1:0] cand_size_r;
  logic               best_av_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [BYTES_W-1:0] best_size_r;
  logic               take;

  assign ok = in_v && heap_ok
           && ((props & qry.req) == qry.req)
           && ((props & pol.forbidden) == '0)
           && ((heap_flags & pol.excl_heap) == '0)
           && !(heap_size < qry.min_bytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_v_r <= 1'b0;
    end else begin
      cand_v_r <= ok && !clear;
    end
    cand_idx_r   <= idx;
    cand_av_r    <= (props & qry.avoid) != '0;
    cand_score_r <= bit_count(props & qry.pref);
    cand_size_r  <= heap_size;
  end

  // avoided status first, then preferred score, then strictly larger heap
  assign take = cand_v_r && (!have_r || (best_av_r && !cand_av_r) ||
                (best_av_r == cand_av_r &&
                 (cand_score_r > best_score_r ||
                  (cand_score_r == best_score_r && cand_size_r > best_size_r))));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      have_r     <= 1'b0;
      best_idx_r <= '0;
    end else if (take) begin
      have_r     <= 1'b1;
      best_idx_r <= cand_idx_r;
    end
    if (take) begin
      best_av_r    <= cand_av_r;
      best_score_r <= cand_score_r;
      best_size_r  <= cand_size_r;
    end
  end

  assign busy = cand_v_r;

endmodule

### rtl/memory_type_selector.sv
// memory type selector top level: table loads, query sequencer, result register
// load transaction: written in the cycle it is accepted, one per cycle while no query is in progress
// query transaction: after acceptance min(type_count, 32) type entries are scanned; one
//   type entry leaves the type table per cycle, then three stages (heap read, qualify, rank)
// the input stalls until the result is written to the output register, also while a result blocks it
// reset clears control and the type count and sets the default policy masks; the tables are undefined until loaded
module memory_type_selector import mts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [PROPS_W-1:0]   in_type_props,
  input  logic [HEAPNUM_W-1:0] in_type_heap,
  input  logic [BYTES_W-1:0]   in_heap_bytes,
  input  logic [PROPS_W-1:0]   in_heap_attr,
  input  logic [PROPS_W-1:0]   in_allowed_types,
  input  logic [PROPS_W-1:0]   in_required_props,
  input  logic [PROPS_W-1:0]   in_preferred_props,
  input  logic [PROPS_W-1:0]   in_avoided_props,
  input  logic [BYTES_W-1:0]   in_min_heap_bytes,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output logic [IDX_W-1:0]     out_chosen_type
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam int TYPE_W = PROPS_W + HEAPNUM_W;
  localparam int HEAP_W = BYTES_W + PROPS_W;

  logic [1:0]        state_r;
  logic [CNT_W-1:0]  type_count_r;
  policy_t           pol_r;
  query_t            qry_r;
  logic [CNT_W-1:0]  cnt_lim_nxt;
  logic [CNT_W-1:0]  cnt_lim_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic              in_acc;
  logic              is_query;
  logic              done;
  logic              type_we;
  logic              heap_we;
  logic [TYPE_W-1:0] type_rdata;
  logic [HEAP_W-1:0] heap_rdata;
  logic              tv_r;
  logic [IDX_W-1:0]  tidx_r;
  logic              hv_r;
  logic [IDX_W-1:0]  hidx_r;
  logic [PROPS_W-1:0] hprops_r;
  logic              hok_r;
  logic [HEAPNUM_W-1:0] t_heap;
  logic              eval_busy;
  logic              have;
  logic [IDX_W-1:0]  best_idx;
  logic              out_valid_r;
  logic              out_found_r;
  logic [IDX_W-1:0]  out_type_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_count_r  <= '0;
      pol_r.forbidden <= 32'h000000f0;
      pol_r.excl_heap <= 32'h00000008;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TYPE_COUNT: type_count_r    <= cfg_wdata[CNT_W-1:0];
        CFG_FORBIDDEN:  pol_r.forbidden <= cfg_wdata;
        CFG_EXCL_HEAP:  pol_r.excl_heap <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign is_query    = in_acc && (in_opcode == OP_QUERY);
  assign cnt_lim_nxt = (type_count_r > CNT_W'(MAX_TYPES)) ? CNT_W'(MAX_TYPES) : type_count_r;

  assign type_we = in_acc && (in_opcode == OP_LOAD_TYPE) && (int'(in_entry_index) < MAX_TYPES);
  assign heap_we = in_acc && (in_opcode == OP_LOAD_HEAP) && (int'(in_entry_index) < MAX_HEAPS);

  mts_ram #(.WIDTH(TYPE_W), .DEPTH(MAX_TYPES), .AW(TYPE_AW)) u_type_ram (
    .clk     (clk),
    .we      (type_we),
    .waddr   (in_entry_index[TYPE_AW-1:0]),
    .wdata   ({in_type_props, in_type_heap}),
    .raddr   (scan_idx_r[TYPE_AW-1:0]),
    .rdata_r (type_rdata)
  );

  assign t_heap = type_rdata[HEAPNUM_W-1:0];

  mts_ram #(.WIDTH(HEAP_W), .DEPTH(MAX_HEAPS), .AW(HEAP_AW)) u_heap_ram (
    .clk     (clk),
    .we      (heap_we),
    .waddr   (in_entry_index[HEAP_AW-1:0]),
    .wdata   ({in_heap_bytes, in_heap_attr}),
    .raddr   (t_heap[HEAP_AW-1:0]),
    .rdata_r (heap_rdata)
  );

  // scan pipeline: type read, heap read, then qualify and rank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
      hv_r <= 1'b0;
    end else begin
      tv_r <= (state_r == ST_SCAN) && qry_r.allowed[scan_idx_r[IDX_W-1:0]];
      hv_r <= tv_r;
    end
    tidx_r   <= scan_idx_r[IDX_W-1:0];
    hidx_r   <= tidx_r;
    hprops_r <= type_rdata[TYPE_W-1:HEAPNUM_W];
    hok_r    <= int'(t_heap) < MAX_HEAPS;
  end

  mts_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (is_query),
    .in_v       (hv_r),
    .idx        (hidx_r),
    .props      (hprops_r),
    .heap_ok    (hok_r),
    .heap_size  (heap_rdata[HEAP_W-1:PROPS_W]),
    .heap_flags (heap_rdata[PROPS_W-1:0]),
    .qry        (qry_r),
    .pol        (pol_r),
    .busy       (eval_busy),
    .have_r     (have),
    .best_idx_r (best_idx)
  );

  assign done = (state_r == ST_DRAIN) && !tv_r && !hv_r && !eval_busy
             && (!out_valid_r || !out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (is_query) begin
            scan_idx_r <= '0;
            state_r    <= (cnt_lim_nxt == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_idx_r <= scan_idx_r + 1'b1;
          if (scan_idx_r == cnt_lim_r - 1'b1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (is_query) begin
      cnt_lim_r       <= cnt_lim_nxt;
      qry_r.allowed   <= in_allowed_types;
      qry_r.req       <= in_required_props;
      qry_r.pref      <= in_preferred_props;
      qry_r.avoid     <= in_avoided_props;
      qry_r.min_bytes <= in_min_heap_bytes;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (done) begin
      out_found_r <= have;
      out_type_r  <= have ? best_idx : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_type = out_type_r;

endmodule
